[hdl/chm_pkg.sv]
// Shared types and codes for the chained hash map.
package chm_pkg;

   localparam int KEY_W   = 64;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;
   localparam int STATUS_W = 3;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_HIT      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ADDED    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 3'd4;

   localparam logic [31:0] DJB2_SEED = 32'd5381;

   typedef struct packed {
      logic               req_type;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  found_value;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type_type;

   typedef struct packed {
      logic busy;
      logic done;
   } hash_stat_type;

endpackage

[hdl/chm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/chm_hash.sv]
// Iterative djb2 hash unit: one key byte per cycle, bucket from the low bits.
module chm_hash #(
   parameter int KEY_BYTES   = 8,
   parameter int BUCKET_BITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [KEY_BYTES*8-1:0]    key,
   output chm_pkg::hash_stat_type    stat,
   output logic [BUCKET_BITS-1:0]    bucket
);

   localparam int KW = KEY_BYTES * 8;
   localparam int CW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

   logic [31:0] h_ff, h_in;
   logic [KW-1:0] key_ff, key_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   always_comb begin
      h_in    = h_ff;
      key_in  = key_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         h_in    = chm_pkg::DJB2_SEED;
         key_in  = key;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // h * 33 + c, wrapping at 32 bits
         h_in   = (h_ff << 5) + h_ff + {24'd0, key_ff[7:0]};
         key_in = key_ff >> 8;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(KEY_BYTES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      h_ff   <= h_in;
      key_ff <= key_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign bucket    = h_ff[BUCKET_BITS-1:0];

endmodule

[hdl/chained_hash_map.sv]
// Chained hash map: request channel in, one response per request out.
// Each request is an insert (req_type 0) or a lookup (req_type 1) of a key.
// The key is hashed one byte per cycle by a djb2 unit, then the bucket head
// and the chain nodes are read from on-chip RAM, one node per cycle.
// A request passes the hash, the head read, the chain walk, a decide step
// and the response register, with an extra link step when a new node is
// appended behind an existing tail; the byte-serial hash and the single
// node read port set its length. One request is in flight at a time:
// req_ready is high only while the block waits for work.
// After reset the bucket heads are cleared in a pass over all BUCKETS
// entries, during which no request is taken. Nodes come from a pool handed
// out in order; once NODES keys are stored, inserts of new keys are rejected.
// The response sits in an output register. If the receiver stalls, the
// next request may still be taken and processed, and it waits at the end
// of its work until the held response has been transferred.
module chained_hash_map #(
   parameter int KEY_BYTES  = 8,
   parameter int VALUE_BITS = 32,
   parameter int BUCKETS    = 1024,
   parameter int NODES      = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  chm_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output chm_pkg::rsp_type_type rsp_data
);

   localparam int KW = KEY_BYTES * 8;
   localparam int VW = (VALUE_BITS < chm_pkg::VALUE_W) ? VALUE_BITS : chm_pkg::VALUE_W;
   localparam int BB = $clog2(BUCKETS);
   localparam int NW = $clog2(NODES);
   localparam int CW = $clog2(NODES + 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HASH   = 3'd2;
   localparam logic [2:0] S_HEAD   = 3'd3;
   localparam logic [2:0] S_NODE   = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;
   localparam logic [2:0] S_LINK   = 3'd6;
   localparam logic [2:0] S_RESP   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [BB-1:0] clr_ff, clr_in;
   logic lookup_ff, lookup_in;
   logic [KW-1:0] key_ff, key_in;
   logic [VW-1:0] val_ff, val_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] last_ff, last_in;
   logic have_last_ff, have_last_in;
   logic hit_ff, hit_in;
   logic [VW-1:0] found_ff, found_in;
   logic [chm_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [CW-1:0] used_ff, used_in;
   logic rsp_valid_ff, rsp_valid_in;
   chm_pkg::rsp_type_type rsp_data_ff, rsp_data_in;

   chm_pkg::hash_stat_type hash_stat;
   logic hash_start;
   logic [BB-1:0] bucket;

   logic head_we;
   logic [BB-1:0] head_waddr;
   logic [NW:0] head_wdata, head_rdata;

   logic key_we, val_we, link_we;
   logic [NW-1:0] val_waddr, link_waddr, node_raddr, new_idx;
   logic [NW:0] link_wdata, link_rdata;
   logic [KW-1:0] key_rdata;
   logic [VW-1:0] val_rdata;

   assign new_idx = used_ff[NW-1:0];

   chm_hash #(
      .KEY_BYTES  (KEY_BYTES),
      .BUCKET_BITS(BB)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_data.key[KW-1:0]),
      .stat  (hash_stat),
      .bucket(bucket)
   );

   chm_ram #(.WIDTH(NW + 1), .DEPTH(BUCKETS)) u_heads (
      .clock  (clock),
      .wr_en  (head_we),
      .wr_addr(head_waddr),
      .wr_data(head_wdata),
      .rd_addr(bucket),
      .rd_data(head_rdata)
   );

   chm_ram #(.WIDTH(KW), .DEPTH(NODES)) u_keys (
      .clock  (clock),
      .wr_en  (key_we),
      .wr_addr(new_idx),
      .wr_data(key_ff),
      .rd_addr(node_raddr),
      .rd_data(key_rdata)
   );

   chm_ram #(.WIDTH(VW), .DEPTH(NODES)) u_values (
      .clock  (clock),
      .wr_en  (val_we),
      .wr_addr(val_waddr),
      .wr_data(val_ff),
      .rd_addr(node_raddr),
      .rd_data(val_rdata)
   );

   chm_ram #(.WIDTH(NW + 1), .DEPTH(NODES)) u_links (
      .clock  (clock),
      .wr_en  (link_we),
      .wr_addr(link_waddr),
      .wr_data(link_wdata),
      .rd_addr(node_raddr),
      .rd_data(link_rdata)
   );

   // The first node comes from the bucket head, later ones from the link
   // just read.
   assign node_raddr = (state_ff == S_HEAD) ? head_rdata[NW-1:0] : link_rdata[NW-1:0];
   assign val_waddr  = hit_ff ? cur_ff : new_idx;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      lookup_in    = lookup_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      have_last_in = have_last_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      hash_start   = 1'b0;
      head_we      = 1'b0;
      head_waddr   = bucket;
      head_wdata   = {1'b1, new_idx};
      key_we       = 1'b0;
      val_we       = 1'b0;
      link_we      = 1'b0;
      link_waddr   = new_idx;
      link_wdata   = '0;

      unique case (state_ff)
         S_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = '0;
            clr_in     = clr_ff + BB'(1);
            if (clr_ff == BB'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               hash_start   = 1'b1;
               lookup_in    = (req_data.req_type == chm_pkg::REQ_LOOKUP);
               key_in       = req_data.key[KW-1:0];
               val_in       = req_data.value[VW-1:0];
               hit_in       = 1'b0;
               have_last_in = 1'b0;
               found_in     = '0;
               state_in     = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_stat.done) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cur_in = head_rdata[NW-1:0];
            if (head_rdata[NW]) begin
               state_in = S_NODE;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_NODE: begin
            if (key_rdata == key_ff) begin
               hit_in = 1'b1;
               if (lookup_ff) begin
                  found_in = val_rdata;
               end
               state_in = S_DECIDE;
            end else begin
               last_in      = cur_ff;
               have_last_in = 1'b1;
               cur_in       = link_rdata[NW-1:0];
               if (!link_rdata[NW]) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            if (lookup_ff) begin
               status_in = hit_ff ? chm_pkg::STATUS_HIT : chm_pkg::STATUS_MISS;
            end else if (hit_ff) begin
               val_we    = 1'b1;
               status_in = chm_pkg::STATUS_UPDATED;
            end else if (used_ff == CW'(NODES)) begin
               status_in = chm_pkg::STATUS_REJECTED;
            end else begin
               key_we    = 1'b1;
               val_we    = 1'b1;
               link_we   = 1'b1;
               head_we   = !have_last_ff;
               used_in   = used_ff + CW'(1);
               status_in = chm_pkg::STATUS_ADDED;
               if (have_last_ff) begin
                  state_in = S_LINK;
               end
            end
         end
         S_LINK: begin
            // The count has already moved on, so the new node is one below it.
            link_we    = 1'b1;
            link_waddr = last_ff;
            link_wdata = {1'b1, NW'(used_ff - CW'(1))};
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.found_value = chm_pkg::VALUE_W'(found_ff);
               rsp_data_in.entry_count = chm_pkg::COUNT_W'(used_ff);
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lookup_ff    <= lookup_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      cur_ff       <= cur_in;
      last_ff      <= last_in;
      have_last_ff <= have_last_in;
      hit_ff       <= hit_in;
      found_ff     <= found_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(NODES))
      else $error("node count exceeds pool size");

   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (hash_stat.busy && state_ff == S_HASH))
      else $error("accepted request did not start the hash unit");

   a_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_stat.done |-> (state_ff == S_HASH))
      else $error("hash result arrived outside the hash state");

   a_count_moves_on_add: assert property (@(posedge clock) disable iff (reset)
      (used_ff != $past(used_ff)) |->
         ($past(state_ff) == S_DECIDE && status_ff == chm_pkg::STATUS_ADDED))
      else $error("node count changed without an append");
`endif

endmodule
